// File: hdl/mmbf_pkg.sv
// Shared types and constants of the mipmap box-filter pyramid.
package mmbf_pkg;

  localparam int LEVEL_W = 4;
  localparam int COORD_W = 12;
  localparam int PIX_W   = 8;
  localparam int SUM_W   = PIX_W + 1;

  // register select bit of paddr (byte address 4*i)
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic [PIX_W-1:0]   value;
    logic               last;
  } result_t;

  localparam int RESULT_W = $bits(result_t);

endpackage

// File: hdl/mipmap_box_filter_pyramid.sv
// Top level of the mipmap box-filter pyramid generator.
// Pixels of a power-of-two greyscale image enter in raster order through a
// two-entry input queue; each item comes back at once as a level-0 result, and
// each completed 2x2 block is averaged (truncating) and climbs to the next
// level, up to min(width_log2, height_log2). Each level that an item climbs
// goes through a registered read of the pair-sum line memory and then an
// averaging step. Results go through a four-entry queue; last marks the
// final result of an item. Sizes are set through the APB port (width_log2
// at 0x0, height_log2 at 0x4, values above MAX_SIZE_LOG2 act as
// MAX_SIZE_LOG2); any write restarts the image. Write only while idle. The
// line memory needs no clearing pass.
module mipmap_box_filter_pyramid import mmbf_pkg::*; #(
  parameter int MAX_SIZE_LOG2 = 12
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic [PIX_W-1:0]   pixel_i,
  output logic               empty,
  input  logic               pop,
  output logic [LEVEL_W-1:0] level_o,
  output logic [COORD_W-1:0] col_o,
  output logic [COORD_W-1:0] row_o,
  output logic [PIX_W-1:0]   value_o,
  output logic               last_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  logic [3:0]       width_q, height_q;
  logic             cfg_wr;
  logic             in_empty, in_pop;
  logic [PIX_W-1:0] in_pixel;
  logic             out_full, out_push;
  result_t          eng_res, out_res;

  // config registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_HEIGHT) ? {28'd0, height_q} : {28'd0, width_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 4'd8;
      height_q <= 4'd8;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_WIDTH) begin
        width_q <= pwdata[3:0];
      end else begin
        height_q <= pwdata[3:0];
      end
    end
  end

  // front: input queue
  mmbf_fifo #(.W(PIX_W), .DEPTH(2)) u_in_q (
    .clk_i, .rst_ni,
    .push_i (push), .wdata_i(pixel_i), .full_o(full),
    .pop_i  (in_pop), .rdata_o(in_pixel), .empty_o(in_empty)
  );

  // back: level walker
  mmbf_engine #(.MAX_SIZE_LOG2(MAX_SIZE_LOG2)) u_engine (
    .clk_i, .rst_ni,
    .clear_i      (cfg_wr),
    .width_log2_i (width_q),
    .height_log2_i(height_q),
    .in_valid_i   (!in_empty),
    .in_pixel_i   (in_pixel),
    .in_pop_o     (in_pop),
    .out_full_i   (out_full),
    .out_push_o   (out_push),
    .out_res_o    (eng_res)
  );

  // result queue
  mmbf_fifo #(.W(RESULT_W), .DEPTH(4)) u_out_q (
    .clk_i, .rst_ni,
    .push_i (out_push), .wdata_i(eng_res), .full_o(out_full),
    .pop_i  (pop), .rdata_o(out_res), .empty_o(empty)
  );

  assign level_o = out_res.level;
  assign col_o   = out_res.col;
  assign row_o   = out_res.row;
  assign value_o = out_res.value;
  assign last_o  = out_res.last;

  // engine only takes an item that is there
  a_pop_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_pop |-> !in_empty) else $error("input queue popped while empty");
  // never pushes into a full result queue
  a_push_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_push |-> !out_full) else $error("result queue pushed while full");
  // a result that carries on to the next level lies below the top level
  a_climb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_push && !eng_res.last) |-> (eng_res.level < LEVEL_W'(MAX_SIZE_LOG2)))
    else $error("climb past top level");
endmodule

// File: hdl/mmbf_fifo.sv
// Small synchronous queue with full and empty flags.
module mmbf_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] wdata_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic [W-1:0] rdata_o,
  output logic         empty_o
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [W-1:0]  mem [DEPTH];
  logic [PW-1:0] wptr_q, rptr_q;
  logic [PW:0]   cnt_q;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == (PW+1)'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end
endmodule

// File: hdl/mmbf_engine.sv
// Level sequencer: walks one pixel up the pyramid, one level per step.
module mmbf_engine import mmbf_pkg::*; #(
  parameter int MAX_SIZE_LOG2 = 12
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             clear_i,
  input  logic [3:0]       width_log2_i,
  input  logic [3:0]       height_log2_i,
  input  logic             in_valid_i,
  input  logic [PIX_W-1:0] in_pixel_i,
  output logic             in_pop_o,
  input  logic             out_full_i,
  output logic             out_push_o,
  output result_t          out_res_o
);
  localparam int LW  = $clog2(MAX_SIZE_LOG2 + 1);
  localparam int HW  = (MAX_SIZE_LOG2 > 1) ? $clog2(MAX_SIZE_LOG2) : 1;
  localparam int CW  = MAX_SIZE_LOG2;
  localparam int CW1 = CW + 1;
  localparam int NL  = MAX_SIZE_LOG2 + 1;
  localparam int LINE_SLOTS = 1 << MAX_SIZE_LOG2;

  typedef enum logic {ST_STEP, ST_AVG} state_e;

  state_e           state_q;
  logic [LW-1:0]    k_q;
  logic [PIX_W-1:0] v_q;
  logic [SUM_W-1:0] s_q, rd_q;
  logic [CW-1:0]    col_q [NL];
  logic [CW-1:0]    row_q [NL];
  logic [PIX_W-1:0] held_q [MAX_SIZE_LOG2];
  logic [SUM_W-1:0] line_mem [LINE_SLOTS];

  logic [LW-1:0]    wl, hl, top, wsh, hsh;
  logic [CW-1:0]    c, r, wmask, hmask, c_nxt, r_nxt;
  logic [CW:0]      wone, hone, base;
  logic [CW-1:0]    idx;
  logic [PIX_W-1:0] v;
  logic [SUM_W-1:0] s;
  logic [SUM_W:0]   avg;
  logic             go, below_top, fed, wr_line;

  assign wl  = (width_log2_i > 4'(MAX_SIZE_LOG2)) ? LW'(MAX_SIZE_LOG2) : LW'(width_log2_i);
  assign hl  = (height_log2_i > 4'(MAX_SIZE_LOG2)) ? LW'(MAX_SIZE_LOG2) : LW'(height_log2_i);
  assign top = (wl < hl) ? wl : hl;

  always_comb begin
    c     = col_q[k_q];
    r     = row_q[k_q];
    v     = (k_q == '0) ? in_pixel_i : v_q;
    wsh   = wl - k_q;
    hsh   = hl - k_q;
    wone  = CW1'(1) << wsh;
    hone  = CW1'(1) << hsh;
    wmask = CW'(wone - 1'b1);
    hmask = CW'(hone - 1'b1);
    // line slots of level k start after those of the lower levels
    base  = (CW1'(1) << wl) - wone;
    idx   = CW'(base + CW1'(c >> 1));
    s     = SUM_W'(held_q[k_q[HW-1:0]]) + SUM_W'(v);
    below_top = (k_q < top);
    fed       = below_top && c[0] && r[0];
    wr_line   = below_top && c[0] && !r[0];
    go        = (state_q == ST_STEP) && ((k_q != '0) || in_valid_i) && !out_full_i;
    c_nxt     = (c == wmask) ? '0 : c + 1'b1;
    r_nxt     = (c == wmask) ? ((r == hmask) ? '0 : r + 1'b1) : r;
    avg       = (SUM_W+1)'(rd_q) + (SUM_W+1)'(s_q);
  end

  assign in_pop_o   = go && (k_q == '0);
  assign out_push_o = go;
  always_comb begin
    out_res_o.level = LEVEL_W'(k_q);
    out_res_o.col   = COORD_W'(c);
    out_res_o.row   = COORD_W'(r);
    out_res_o.value = v;
    out_res_o.last  = !fed;
  end

  always_ff @(posedge clk_i) begin
    if (go && wr_line) begin
      line_mem[idx] <= s;
    end
    if (go && fed) begin
      rd_q <= line_mem[idx];
      s_q  <= s;
    end
    if (go && below_top && !c[0]) begin
      held_q[k_q[HW-1:0]] <= v;
    end
    if (state_q == ST_AVG) begin
      v_q <= PIX_W'(avg >> 2);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_STEP;
      k_q     <= '0;
      for (int i = 0; i < NL; i++) begin
        col_q[i] <= '0;
        row_q[i] <= '0;
      end
    end else if (clear_i) begin
      state_q <= ST_STEP;
      k_q     <= '0;
      for (int i = 0; i < NL; i++) begin
        col_q[i] <= '0;
        row_q[i] <= '0;
      end
    end else begin
      case (state_q)
        ST_STEP: begin
          if (go) begin
            col_q[k_q] <= c_nxt;
            row_q[k_q] <= r_nxt;
            if (fed) begin
              state_q <= ST_AVG;
            end else begin
              k_q <= '0;
            end
          end
        end
        ST_AVG: begin
          k_q     <= k_q + 1'b1;
          state_q <= ST_STEP;
        end
        default: state_q <= ST_STEP;
      endcase
    end
  end
endmodule
